[rtl/rpt_pkg.sv]
// Shared types and constants for the reconnect penalty table.
// No dependencies; used by reconnect_penalty_table.
`default_nettype none

package rpt_pkg;

    // field widths fixed by the item format
    localparam int ADDR_W = 32;
    localparam int TIME_W = 48;
    localparam int SLOT_FIELD_W = 6;

    // item kinds
    localparam logic FUNC_CONNECT = 1'b0;
    localparam logic FUNC_DISCONNECT = 1'b1;

    // result codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_REFUSED = 2'd1,
        STATUS_UNKNOWN = 2'd2,
        STATUS_FULL    = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BREAD,
        ST_SCAN,
        ST_CHECK,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

[rtl/rpt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the penalty and binding stores.
`default_nettype none

module rpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/reconnect_penalty_table.sv]
// Reconnect penalty table: admits or refuses connections from peers that
// recently left with an error. A connect item, or a disconnect item that
// reports an error, scans the penalty store one entry per cycle through a
// single read port and one address comparator, stopping at the first match.
// With no match, a connect scans every entry, then passes through ST_CHECK
// and ST_RESULT to load its result into the output register; an error
// disconnect first reads the slot's bound address in ST_BREAD. Out-of-range
// slots, unknown slots and clean disconnects go from ST_IDLE straight to
// ST_RESULT and load their result from there, with no scan. One item is
// in work at a time: in_stall stays high until the result is loaded and
// drops the cycle after, and a stalled result holds off the next item.
// The user must write penalty_limit through the cfg port only while idle;
// the block itself does not enforce this. Depends on rpt_pkg and rpt_ram.
`default_nettype none

module reconnect_penalty_table #(
    parameter int PENALTY_ENTRIES  = 256,
    parameter int CONNECTION_SLOTS = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // config write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rpt_pkg::TIME_W-1:0]      cfg_data,
    // input item channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            func,
    input  wire logic [rpt_pkg::ADDR_W-1:0]      peer_address,
    input  wire logic [rpt_pkg::SLOT_FIELD_W-1:0] connection_id,
    input  wire logic                            had_error,
    input  wire logic [rpt_pkg::TIME_W-1:0]      time_now,
    // result item channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           status
);

    localparam int IDX_W  = $clog2(PENALTY_ENTRIES);
    localparam int CNT_W  = $clog2(PENALTY_ENTRIES + 1);
    localparam int SLOT_W = $clog2(CONNECTION_SLOTS);
    localparam int PW     = rpt_pkg::ADDR_W + rpt_pkg::TIME_W;

    rpt_pkg::state_t  state_reg, state_next;
    rpt_pkg::status_t res_reg, res_next;
    rpt_pkg::status_t status_reg;
    logic             out_valid_reg, out_valid_next;
    logic             out_load;

    logic [rpt_pkg::TIME_W-1:0] limit_reg;

    // item fields held during the work
    logic                       func_reg, func_next;
    logic [SLOT_W-1:0]          slot_reg, slot_next;
    logic [rpt_pkg::TIME_W-1:0] now_reg, now_next;
    logic [rpt_pkg::ADDR_W-1:0] key_reg, key_next;

    // scan control
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       pend_reg, pend_next;
    logic [IDX_W-1:0]           pend_idx_reg, pend_idx_next;
    logic                       pend_vbit_reg, pend_vbit_next;
    logic                       found_reg, found_next;
    logic [IDX_W-1:0]           hit_idx_reg, hit_idx_next;
    logic [rpt_pkg::TIME_W-1:0] hit_time_reg, hit_time_next;
    logic                       free_found_reg, free_found_next;
    logic [IDX_W-1:0]           free_idx_reg, free_idx_next;

    // valid bits
    logic [PENALTY_ENTRIES-1:0]  pvalid_reg;
    logic [CONNECTION_SLOTS-1:0] bvalid_reg;
    logic                        pv_set, pv_clr;
    logic [IDX_W-1:0]            pv_idx;
    logic                        bv_set, bv_clr;
    logic [SLOT_W-1:0]           bv_idx;

    // memory ports
    logic              p_we;
    logic [IDX_W-1:0]  p_waddr, p_raddr;
    logic [PW-1:0]     p_wdata, p_rdata;
    logic              b_we;
    logic [SLOT_W-1:0] b_raddr;
    logic [rpt_pkg::ADDR_W-1:0] b_rdata;

    logic              in_range;
    logic [SLOT_W-1:0] slot_in;
    logic              issue;
    logic              hit;
    logic [rpt_pkg::TIME_W:0] expiry;
    logic              refused;

    // penalty store: address in the upper bits, time in the lower bits
    rpt_ram #(
        .WIDTH (PW),
        .DEPTH (PENALTY_ENTRIES)
    ) u_penalty_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    // address bound to each connection slot
    rpt_ram #(
        .WIDTH (rpt_pkg::ADDR_W),
        .DEPTH (CONNECTION_SLOTS)
    ) u_bound_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (slot_reg),
        .wdata (key_reg),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != rpt_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    // slot decode from the input port
    assign in_range = (32'(connection_id) < 32'(CONNECTION_SLOTS));
    assign slot_in  = SLOT_W'(connection_id);
    assign b_raddr  = slot_in;

    // scan read side and comparator
    assign issue   = (state_reg == rpt_pkg::ST_SCAN) && (cnt_reg < CNT_W'(PENALTY_ENTRIES));
    assign p_raddr = cnt_reg[IDX_W-1:0];
    assign hit     = pend_reg && pend_vbit_reg
                     && (p_rdata[PW-1:rpt_pkg::TIME_W] == key_reg);

    // penalty test at 49 bits
    assign expiry  = {1'b0, hit_time_reg} + {1'b0, limit_reg};
    assign refused = found_reg && (hit_time_reg != '0)
                     && ({1'b0, now_reg} < expiry);

    assign p_waddr = found_reg ? hit_idx_reg : free_idx_reg;
    assign p_wdata = {key_reg, now_reg};

    // sequencer next state and strobes
    always_comb
    begin
        state_next      = state_reg;
        res_next        = res_reg;
        func_next       = func_reg;
        slot_next       = slot_reg;
        now_next        = now_reg;
        key_next        = key_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        pend_vbit_next  = pend_vbit_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_time_next   = hit_time_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pv_set          = 1'b0;
        pv_clr          = 1'b0;
        pv_idx          = hit_idx_reg;
        bv_set          = 1'b0;
        bv_clr          = 1'b0;
        bv_idx          = slot_reg;
        p_we            = 1'b0;
        b_we            = 1'b0;
        out_load        = 1'b0;

        case (state_reg)
            rpt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next       = func;
                    slot_next       = slot_in;
                    now_next        = time_now;
                    key_next        = peer_address;
                    cnt_next        = '0;
                    pend_next       = 1'b0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    if (!in_range)
                    begin
                        res_next   = rpt_pkg::STATUS_UNKNOWN;
                        state_next = rpt_pkg::ST_RESULT;
                    end
                    else if (func == rpt_pkg::FUNC_CONNECT)
                    begin
                        state_next = rpt_pkg::ST_SCAN;
                    end
                    else if (!bvalid_reg[slot_in])
                    begin
                        res_next   = rpt_pkg::STATUS_UNKNOWN;
                        state_next = rpt_pkg::ST_RESULT;
                    end
                    else if (!had_error)
                    begin
                        // clean disconnect just frees the slot
                        bv_clr     = 1'b1;
                        bv_idx     = slot_in;
                        res_next   = rpt_pkg::STATUS_OK;
                        state_next = rpt_pkg::ST_RESULT;
                    end
                    else
                    begin
                        state_next = rpt_pkg::ST_BREAD;
                    end
                end
            end

            rpt_pkg::ST_BREAD:
            begin
                // bound address becomes the search key
                key_next   = b_rdata;
                state_next = rpt_pkg::ST_SCAN;
            end

            rpt_pkg::ST_SCAN:
            begin
                pend_next      = issue;
                pend_idx_next  = cnt_reg[IDX_W-1:0];
                pend_vbit_next = pvalid_reg[cnt_reg[IDX_W-1:0]];
                if (issue)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                // note the lowest free entry
                if (pend_reg && !pend_vbit_reg && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = pend_idx_reg;
                end
                if (hit)
                begin
                    found_next    = 1'b1;
                    hit_idx_next  = pend_idx_reg;
                    hit_time_next = p_rdata[rpt_pkg::TIME_W-1:0];
                    state_next    = rpt_pkg::ST_CHECK;
                end
                else if (!issue && !pend_reg)
                begin
                    state_next = rpt_pkg::ST_CHECK;
                end
            end

            rpt_pkg::ST_CHECK:
            begin
                state_next = rpt_pkg::ST_RESULT;
                if (func_reg == rpt_pkg::FUNC_CONNECT)
                begin
                    if (refused)
                    begin
                        res_next = rpt_pkg::STATUS_REFUSED;
                    end
                    else
                    begin
                        // drop expired entry and bind the slot
                        pv_clr   = found_reg;
                        pv_idx   = hit_idx_reg;
                        b_we     = 1'b1;
                        bv_set   = 1'b1;
                        res_next = rpt_pkg::STATUS_OK;
                    end
                end
                else
                begin
                    // error disconnect records the penalty if there is room
                    bv_clr = 1'b1;
                    if (found_reg || free_found_reg)
                    begin
                        p_we     = 1'b1;
                        pv_set   = 1'b1;
                        pv_idx   = p_waddr;
                        res_next = rpt_pkg::STATUS_OK;
                    end
                    else
                    begin
                        res_next = rpt_pkg::STATUS_FULL;
                    end
                end
            end

            rpt_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = rpt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rpt_pkg::ST_IDLE;
            end
        endcase
    end

    // output register hand-off
    always_comb
    begin
        out_valid_next = (out_valid_reg && out_stall) || out_load;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rpt_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            limit_reg      <= '0;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= '0;
            bvalid_reg <= '0;
        end
        else
        begin
            if (pv_set)
            begin
                pvalid_reg[pv_idx] <= 1'b1;
            end
            else if (pv_clr)
            begin
                pvalid_reg[pv_idx] <= 1'b0;
            end
            if (bv_set)
            begin
                bvalid_reg[bv_idx] <= 1'b1;
            end
            else if (bv_clr)
            begin
                bvalid_reg[bv_idx] <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg       <= res_next;
        func_reg      <= func_next;
        slot_reg      <= slot_next;
        now_reg       <= now_next;
        key_reg       <= key_next;
        pend_idx_reg  <= pend_idx_next;
        pend_vbit_reg <= pend_vbit_next;
        hit_idx_reg   <= hit_idx_next;
        hit_time_reg  <= hit_time_next;
        free_idx_reg  <= free_idx_next;
        if (out_load)
        begin
            status_reg <= res_reg;
        end
    end

endmodule

`default_nettype wire
